[rtl/ilc_pkg.sv]
// ----------------------------------------------------------------------------
// ilc_pkg
// Shared types and constants of the integer literal checker.
// ----------------------------------------------------------------------------
package ilc_pkg;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_LX    = 8'h78;

    localparam logic [1:0] RX_DEC = 2'd0;
    localparam logic [1:0] RX_OCT = 2'd1;
    localparam logic [1:0] RX_HEX = 2'd2;

    localparam logic [1:0] MODE_U64 = 2'd0;
    localparam logic [1:0] MODE_U32 = 2'd1;
    localparam logic [1:0] MODE_S32 = 2'd2;
    localparam logic [1:0] MODE_S64 = 2'd3;

    localparam logic [63:0] LIM_S32_NEG = 64'd2147483648;
    localparam logic [63:0] LIM_S32_POS = 64'd2147483647;
    localparam logic [63:0] LIM_U32     = 64'd4294967295;
    localparam logic [63:0] LIM_S64_POS = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] LIM_S64_NEG = 64'h8000_0000_0000_0000;

    typedef enum logic [4:0] {
        PH_START  = 5'b00001,
        PH_BODY   = 5'b00010,
        PH_AZERO  = 5'b00100,
        PH_A0X    = 5'b01000,
        PH_DIGITS = 5'b10000
    } t_phase;

    // classified character
    typedef struct packed {
        logic       is_plus;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       is_hex;
        logic [3:0] dval;
        logic       last;
    } t_cls;

    // finished literal before the range check
    typedef struct packed {
        logic        pre_ok;
        logic        neg;
        logic [1:0]  mode;
        logic [63:0] acc;
    } t_raw;

endpackage

[rtl/integer_literal_checker_core.sv]
// ----------------------------------------------------------------------------
// integer_literal_checker_core
// Checks and converts integer literals streamed one character per item.
//
// Input queue: drive i_char_code and i_is_last with push high; the character
// is taken at a clock edge where full is low. Mark the final character of a
// literal with i_is_last. Output queue: while empty is low, o_ok and
// o_parsed_value hold the oldest result; raise pop to take it. Each literal
// gives exactly one result.
// Throughput: one character per cycle while the result queue has room, set by
// the combinational multiply-by-base and add in the parser.
// Path: the character queue registers each character, the parser writes a
// literal's result into the result queue, and that queue's head drives the output.
// Stall: while pop is held off, the result queue fills, the parser holds
// at the next last character, the character queue fills and full rises.
// Reset: synchronous, active low on i_rst_n; queues empty, parser at the
// start of a literal, range mode back to unsigned 64 bit.
// Configuration: write i_cfg_wdata with i_cfg_we while the block is idle.
// ----------------------------------------------------------------------------
module integer_literal_checker_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_last,
    output logic        empty,
    input  logic        pop,
    output logic        o_ok,
    output logic [63:0] o_parsed_value
);
    import ilc_pkg::*;

    logic w_cls_valid;
    t_cls w_cls;
    logic w_take;
    logic w_rq_full;
    logic w_rq_push;
    t_raw w_raw;

    ilc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_char_code (i_char_code),
        .i_is_last   (i_is_last),
        .o_valid     (w_cls_valid),
        .o_cls       (w_cls),
        .i_take      (w_take)
    );

    ilc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_cls_valid),
        .i_cls       (w_cls),
        .o_take      (w_take),
        .i_rq_full   (w_rq_full),
        .o_rq_push   (w_rq_push),
        .o_raw       (w_raw)
    );

    ilc_rq u_rq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (w_rq_push),
        .i_raw          (w_raw),
        .o_full         (w_rq_full),
        .o_empty        (empty),
        .i_pop          (pop),
        .o_ok           (o_ok),
        .o_parsed_value (o_parsed_value)
    );

endmodule

[rtl/ilc_front.sv]
// ----------------------------------------------------------------------------
// ilc_front
// Classifies each incoming character and queues it for the parser.
// ----------------------------------------------------------------------------
module ilc_front (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic [7:0]  i_char_code,
    input  logic        i_is_last,
    output logic        o_valid,
    output ilc_pkg::t_cls o_cls,
    input  logic        i_take
);
    import ilc_pkg::*;

    t_cls               w_cls;
    t_cls               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, n_wptr;
    logic [Q_PTR_W-1:0] r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_cnt,  n_cnt;
    logic               w_wr, w_rd;

    always_comb begin
        w_cls          = '0;
        w_cls.last     = i_is_last;
        w_cls.is_plus  = (i_char_code == CH_PLUS);
        w_cls.is_minus = (i_char_code == CH_MINUS);
        w_cls.is_zero  = (i_char_code == CH_0);
        w_cls.is_x     = (i_char_code == CH_LX) || (i_char_code == CH_UX);
        case (i_char_code) inside
            [CH_0:CH_9]: begin
                w_cls.is_hex = 1'b1;
                w_cls.dval   = i_char_code[3:0];
            end
            [CH_LA:CH_LF], [CH_UA:CH_UF]: begin
                // low three bits give 1..6 for a..f
                w_cls.is_hex = 1'b1;
                w_cls.dval   = 4'(i_char_code[2:0] + 3'd1) + 4'd8;
            end
            default: begin
                w_cls.is_hex = 1'b0;
            end
        endcase
    end

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cls   = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_take && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= w_cls;
        end
    end

endmodule

[rtl/ilc_back.sv]
// ----------------------------------------------------------------------------
// ilc_back
// Parser: phase, sign, base, accumulator; one char per cycle unless rq full.
// ----------------------------------------------------------------------------
module ilc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_wdata,
    input  logic          i_valid,
    input  ilc_pkg::t_cls i_cls,
    output logic          o_take,
    input  logic          i_rq_full,
    output logic          o_rq_push,
    output ilc_pkg::t_raw o_raw
);
    import ilc_pkg::*;

    logic [1:0]  r_mode;
    t_phase      r_phase, n_phase;
    logic        r_neg, n_neg;
    logic [1:0]  r_radix, n_radix;
    logic [63:0] r_acc, n_acc;
    logic        r_failed, n_failed;
    logic        w_digit;
    logic        w_too_big;
    logic [67:0] w_prod;
    logic [68:0] w_wide;

    // a last character needs room in the result queue
    assign o_take    = i_valid && (!i_cls.last || !i_rq_full);
    assign o_rq_push = o_take && i_cls.last;

    always_comb begin
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_radix  = r_radix;
        n_acc    = r_acc;
        n_failed = r_failed;
        w_digit  = 1'b0;
        case (r_phase)
            PH_START: begin
                if (i_cls.is_plus) begin
                    n_phase = PH_BODY;
                end else if (i_cls.is_minus) begin
                    n_neg   = 1'b1;
                    n_phase = PH_BODY;
                end else if (i_cls.is_zero) begin
                    n_phase = PH_AZERO;
                    n_acc   = '0;
                end else begin
                    n_radix = RX_DEC;
                    w_digit = 1'b1;
                end
            end
            PH_BODY: begin
                if (i_cls.is_zero) begin
                    n_phase = PH_AZERO;
                    n_acc   = '0;
                end else begin
                    n_radix = RX_DEC;
                    w_digit = 1'b1;
                end
            end
            PH_AZERO: begin
                if (i_cls.is_x) begin
                    n_phase = PH_A0X;
                end else begin
                    n_radix = RX_OCT;
                    w_digit = 1'b1;
                end
            end
            PH_A0X: begin
                n_radix = RX_HEX;
                w_digit = 1'b1;
            end
            default: begin
                w_digit = 1'b1;
            end
        endcase

        case (n_radix)
            RX_OCT: begin
                w_prod    = {1'b0, r_acc, 3'b000};
                w_too_big = i_cls.dval[3];
            end
            RX_HEX: begin
                w_prod    = {r_acc, 4'b0000};
                w_too_big = 1'b0;
            end
            default: begin
                w_prod    = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
                w_too_big = (i_cls.dval > 4'd9);
            end
        endcase
        w_wide = {1'b0, w_prod} + 69'(i_cls.dval);

        if (w_digit) begin
            n_phase = PH_DIGITS;
            if (!r_failed) begin
                if (!i_cls.is_hex || w_too_big) begin
                    n_failed = 1'b1;
                end else if (w_wide[68:64] != '0) begin
                    n_failed = 1'b1;
                end else begin
                    n_acc = w_wide[63:0];
                end
            end
        end
    end

    always_comb begin
        o_raw.pre_ok = !n_failed && !(n_phase inside {PH_START, PH_BODY, PH_A0X});
        o_raw.neg    = n_neg;
        o_raw.mode   = r_mode;
        o_raw.acc    = n_acc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_U64;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_START;
            r_neg    <= 1'b0;
            r_radix  <= RX_DEC;
            r_acc    <= '0;
            r_failed <= 1'b0;
        end else if (o_take) begin
            if (i_cls.last) begin
                // drop literal state for the next one
                r_phase  <= PH_START;
                r_neg    <= 1'b0;
                r_radix  <= RX_DEC;
                r_acc    <= '0;
                r_failed <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_neg    <= n_neg;
                r_radix  <= n_radix;
                r_acc    <= n_acc;
                r_failed <= n_failed;
            end
        end
    end

`ifndef SYNTHESIS
    a_start_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_START) |-> (r_acc == '0 && !r_neg && !r_failed))
        else $error("start phase carries literal state");
    a_hex_in_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_radix == RX_HEX) |-> (r_phase == PH_DIGITS))
        else $error("hex radix outside digit phase");
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rq_push |-> !i_rq_full)
        else $error("result pushed into full queue");
`endif

endmodule

[rtl/ilc_rq.sv]
// ----------------------------------------------------------------------------
// ilc_rq
// Result queue with the final range check and sign application at its head.
// ----------------------------------------------------------------------------
module ilc_rq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ilc_pkg::t_raw i_raw,
    output logic          o_full,
    output logic          o_empty,
    input  logic          i_pop,
    output logic          o_ok,
    output logic [63:0]   o_parsed_value
);
    import ilc_pkg::*;

    t_raw               r_mem [Q_DEPTH];
    t_raw               w_head;
    logic [Q_PTR_W-1:0] r_wptr, n_wptr;
    logic [Q_PTR_W-1:0] r_rptr, n_rptr;
    logic [Q_CNT_W-1:0] r_cnt,  n_cnt;
    logic               w_wr, w_rd;
    logic               w_in_range;

    assign o_full  = (r_cnt == Q_CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign w_head  = r_mem[r_rptr];

    always_comb begin
        case (w_head.mode)
            MODE_U64: w_in_range = !w_head.neg;
            MODE_U32: w_in_range = !w_head.neg && (w_head.acc <= LIM_U32);
            MODE_S32: w_in_range = w_head.acc <= (w_head.neg ? LIM_S32_NEG : LIM_S32_POS);
            default:  w_in_range = w_head.acc <= (w_head.neg ? LIM_S64_NEG : LIM_S64_POS);
        endcase
        o_ok = w_head.pre_ok && w_in_range;
        if (!o_ok) begin
            o_parsed_value = '0;
        end else if (w_head.neg) begin
            o_parsed_value = 64'(~w_head.acc + 64'd1);
        end else begin
            o_parsed_value = w_head.acc;
        end
    end

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (w_rd) begin
            n_rptr = (r_rptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + 1'b1;
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_raw;
        end
    end

endmodule

[bench/integer_literal_checker_core_tb.sv]
// ----------------------------------------------------------------------------
// integer_literal_checker_core_tb
// Streams integer literals character by character into the checker under all
// four range modes, first from a fixed table of corner cases, then as random
// literals (mostly well formed, some broken, some raw byte noise). A model of
// the parser here predicts untyped results; results are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module integer_literal_checker_core_tb;

    import ilc_pkg::*;

    localparam int N_ITEMS = 450;
    localparam int N_ROWS = 23;

    typedef struct {
        logic [1:0]  mode;
        string       text;
        bit          typed;
        bit          ok;
        logic [63:0] value;
    } t_row;

    typedef struct {
        bit          ok;
        logic [63:0] value;
    } t_literal_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [1:0]  i_cfg_wdata = 2'd0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_is_last = 1'b0;
    logic        empty;
    logic        pop = 1'b0;
    logic        o_ok;
    logic [63:0] o_parsed_value;

    // parser state mirrored by the bench
    logic [1:0]  mode_q = MODE_U64;
    t_phase      lit_phase = PH_START;
    logic        lit_neg = 1'b0;
    logic [1:0]  lit_radix = RX_DEC;
    logic [63:0] lit_mag = 64'd0;
    logic        lit_bad = 1'b0;

    t_literal_result expected_literals[$];
    logic [7:0]      lit_chars[$];
    int              mismatches = 0;
    int              chars_sent = 0;
    bit              steady = 1'b0;

    // corner cases; untyped rows rely on the parser model
    t_row corner_rows[N_ROWS] = '{
        '{MODE_U64, "0",                    1, 1, 64'd0},
        '{MODE_U64, "+",                    1, 0, 64'd0},
        '{MODE_U64, "-5",                   1, 0, 64'd0},
        '{MODE_U64, "1+",                   1, 0, 64'd0},
        '{MODE_U64, "0x",                   1, 0, 64'd0},
        '{MODE_U64, "0X1F",                 1, 1, 64'd31},
        '{MODE_U64, "09",                   1, 0, 64'd0},
        '{MODE_U64, "017",                  1, 1, 64'd15},
        '{MODE_U64, "12a",                  1, 0, 64'd0},
        '{MODE_U64, "7\377",                1, 0, 64'd0},
        '{MODE_U64, "0xAbC",                0, 0, 64'd0},
        '{MODE_U64, "0xffffffffffffffff",   1, 1, 64'hFFFF_FFFF_FFFF_FFFF},
        '{MODE_U64, "18446744073709551616", 1, 0, 64'd0},
        '{MODE_U64, "0x1ffffffffffffffff1", 1, 0, 64'd0},
        '{MODE_U32, "4294967295",           1, 1, 64'd4294967295},
        '{MODE_U32, "4294967296",           1, 0, 64'd0},
        '{MODE_S32, "-0",                   1, 1, 64'd0},
        '{MODE_S32, "-",                    1, 0, 64'd0},
        '{MODE_S32, "-2147483648",          1, 1, 64'hFFFF_FFFF_8000_0000},
        '{MODE_S32, "2147483648",           1, 0, 64'd0},
        '{MODE_S32, "-0x7fffffff",          0, 0, 64'd0},
        '{MODE_S64, "-9223372036854775808", 1, 1, 64'h8000_0000_0000_0000},
        '{MODE_S64, "0x8000000000000000",   1, 0, 64'd0}
    };

    integer_literal_checker_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .push           (push),
        .full           (full),
        .i_char_code    (i_char_code),
        .i_is_last      (i_is_last),
        .empty          (empty),
        .pop            (pop),
        .o_ok           (o_ok),
        .o_parsed_value (o_parsed_value)
    );

    always #6 i_clk = ~i_clk;

    function automatic void clear_literal();
        lit_phase = PH_START;
        lit_neg   = 1'b0;
        lit_radix = RX_DEC;
        lit_mag   = 64'd0;
        lit_bad   = 1'b0;
    endfunction

    // add one character at the tail of the literal being built
    function automatic void append_char(input logic [7:0] c);
        lit_chars.insert(lit_chars.size(), c);
    endfunction

    function automatic void add_digit(input logic [7:0] c);
        logic [63:0] b;
        logic [63:0] d;
        b = (lit_radix == RX_OCT) ? 64'd8 : (lit_radix == RX_HEX) ? 64'd16 : 64'd10;
        lit_phase = PH_DIGITS;
        if (lit_bad) return;
        if (c >= CH_0 && c <= CH_9) d = 64'(c - CH_0);
        else if (c >= CH_LA && c <= CH_LF) d = 64'(c - CH_LA) + 64'd10;
        else if (c >= CH_UA && c <= CH_UF) d = 64'(c - CH_UA) + 64'd10;
        else begin
            lit_bad = 1'b1;
            return;
        end
        if (d >= b || lit_mag > (64'hFFFF_FFFF_FFFF_FFFF - d) / b) begin
            lit_bad = 1'b1;
            return;
        end
        lit_mag = lit_mag * b + d;
    endfunction

    function automatic void body_first(input logic [7:0] c);
        if (c == CH_0) begin
            lit_phase = PH_AZERO;
            lit_mag = 64'd0;
        end else begin
            lit_radix = RX_DEC;
            add_digit(c);
        end
    endfunction

    // advance the parser by one character; returns 1 when a result is due
    function automatic bit parse_char(input logic [7:0] c, input bit last,
                                      output t_literal_result r);
        logic [63:0] lim;
        bit ok;
        case (lit_phase)
            PH_START: begin
                if (c == CH_PLUS) lit_phase = PH_BODY;
                else if (c == CH_MINUS) begin
                    lit_neg = 1'b1;
                    lit_phase = PH_BODY;
                end else body_first(c);
            end
            PH_BODY: body_first(c);
            PH_AZERO: begin
                if (c == CH_LX || c == CH_UX) lit_phase = PH_A0X;
                else begin
                    lit_radix = RX_OCT;
                    add_digit(c);
                end
            end
            PH_A0X: begin
                lit_radix = RX_HEX;
                add_digit(c);
            end
            default: add_digit(c);
        endcase
        if (!last) return 1'b0;
        ok = !lit_bad && lit_phase != PH_START && lit_phase != PH_BODY &&
             lit_phase != PH_A0X;
        case (mode_q)
            MODE_U64: begin
                lim = 64'hFFFF_FFFF_FFFF_FFFF;
                if (lit_neg) ok = 1'b0;
            end
            MODE_U32: begin
                lim = LIM_U32;
                if (lit_neg) ok = 1'b0;
            end
            MODE_S32: lim = lit_neg ? LIM_S32_NEG : LIM_S32_POS;
            default:  lim = lit_neg ? LIM_S64_NEG : LIM_S64_POS;
        endcase
        if (lit_mag > lim) ok = 1'b0;
        r.ok = ok;
        r.value = !ok ? 64'd0 : lit_neg ? 64'd0 - lit_mag : lit_mag;
        clear_literal();
        return 1'b1;
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    // drain the parser, then write the range mode
    task automatic write_mode(input logic [1:0] m);
        push <= 1'b0;
        while (expected_literals.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_q = m;
    endtask

    // send lit_chars as one literal; a typed result replaces the prediction
    task automatic send_literal(input bit typed, input bit ok, input logic [63:0] value);
        t_literal_result r;
        for (int i = 0; i < lit_chars.size(); i++) begin
            if (!steady && $urandom_range(99) < 5) begin
                push <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            push <= 1'b1;
            i_char_code <= lit_chars[i];
            i_is_last <= (i == lit_chars.size() - 1);
            do @(posedge i_clk); while (full);
            chars_sent++;
            if (parse_char(lit_chars[i], i == lit_chars.size() - 1, r)) begin
                if (typed) begin
                    r.ok = ok;
                    r.value = value;
                end
                expected_literals.insert(expected_literals.size(), r);
            end
        end
    endtask

    task automatic make_literal();
        int          kind;
        int          sign;
        int          form;
        int          sel;
        int          sub;
        logic [63:0] mag;
        logic [63:0] b;
        logic [63:0] d;
        logic [7:0]  digs[$];
        logic [63:0] lims[4];
        lims = '{LIM_S32_POS, LIM_U32, LIM_S64_POS, 64'hFFFF_FFFF_FFFF_FFFD};
        lit_chars.delete();
        kind = $urandom_range(99);
        if (kind >= 90) begin
            // raw byte noise
            repeat ($urandom_range(1, 4)) append_char(8'($urandom_range(255)));
            return;
        end
        sign = $urandom_range(3);
        form = $urandom_range(2);
        sel = $urandom_range(9);
        if (sel < 4) mag = 64'($urandom_range(999));
        else if (sel < 7) mag = {$urandom, $urandom} >> $urandom_range(63);
        else mag = lims[$urandom_range(3)] + 64'($urandom_range(4)) - 64'd2;
        if (sign == 2) append_char(CH_PLUS);
        if (sign == 3) append_char(CH_MINUS);
        if (form == 2) begin
            append_char(CH_0);
            append_char($urandom_range(1) ? CH_UX : CH_LX);
        end else if (form == 1) begin
            append_char(CH_0);
        end
        b = (form == 2) ? 64'd16 : (form == 1) ? 64'd8 : 64'd10;
        do begin
            d = mag % b;
            if (d < 10) digs.push_front(CH_0 + 8'(d));
            else digs.push_front(($urandom_range(1) ? CH_UA : CH_LA) + 8'(d - 10));
            mag = mag / b;
        end while (mag != 0);
        foreach (digs[i]) append_char(digs[i]);
        // one digit too many: pushes near-limit 64-bit values over 64 bits
        if ($urandom_range(19) == 0) append_char(CH_0 + 8'($urandom_range(7)));
        if (kind >= 75) begin
            sub = $urandom_range(3);
            if (sub == 0) begin
                lit_chars.delete();
                append_char($urandom_range(1) ? CH_PLUS : CH_MINUS);
            end else if (sub == 1) begin
                lit_chars.delete();
                if (sign == 3) append_char(CH_MINUS);
                append_char(CH_0);
                append_char($urandom_range(1) ? CH_UX : CH_LX);
            end else begin
                lit_chars[$urandom_range(lit_chars.size() - 1)] = 8'($urandom_range(255));
            end
        end
    endtask

    // result side: check, then choose pop for the next edge
    initial begin
        t_literal_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) begin
                if (expected_literals.size() == 0) begin
                    note_mismatch($sformatf("result with nothing expected: ok=%0b value=%h",
                                            o_ok, o_parsed_value));
                end else begin
                    want = expected_literals.pop_front();
                    if (o_ok !== want.ok || o_parsed_value !== want.value)
                        note_mismatch($sformatf("expected ok=%0b value=%h, got ok=%0b value=%h",
                                                want.ok, want.value, o_ok, o_parsed_value));
                end
            end
            pop <= steady || ($urandom_range(99) >= 10);
        end
    end

    initial begin
        int lit_count;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        write_mode(MODE_U64);
        foreach (corner_rows[r]) begin
            if (corner_rows[r].mode != mode_q) write_mode(corner_rows[r].mode);
            lit_chars.delete();
            for (int i = 0; i < corner_rows[r].text.len(); i++)
                append_char(corner_rows[r].text[i]);
            send_literal(corner_rows[r].typed, corner_rows[r].ok, corner_rows[r].value);
        end
        lit_count = 0;
        while (chars_sent < N_ITEMS) begin
            if ($urandom_range(7) == 0) write_mode(2'($urandom_range(3)));
            // hold both sides busy for a stretch of literals
            steady = (lit_count >= 12 && lit_count < 24);
            make_literal();
            send_literal(1'b0, 1'b0, 64'd0);
            lit_count++;
        end
        steady = 1'b0;
        push <= 1'b0;
        while (expected_literals.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #3_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
